// ===== src/ist_pkg.sv =====
// Shared types and codes for the integer set table.
// No dependencies; imported by every module of the block.
package ist_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_ABSENT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 7;

    // Memory port controls from the sequencer to the element store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

// ===== src/ist_store.sv =====
// Element store: single-port-write, single-port-read memory, registered read.
// Depends on ist_pkg.
module ist_store
    import ist_pkg::*;
#(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW    = 6
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_mem_ctl,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_mem_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ist_ctrl.sv =====
// Sequencer for the set table: linear scan with one shared compare, then update.
// Depends on ist_pkg; drives the ports of ist_store.
module ist_ctrl
    import ist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64,
    parameter int unsigned AW       = 6,
    parameter int unsigned CW       = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_op,
    input  logic [DATA_W-1:0]  i_value,
    output logic               busy,
    output logic               o_valid,
    output logic               o_ok,
    output logic [1:0]         o_status,
    output logic [COUNT_W-1:0] o_item_count,
    output t_mem_ctl           o_mem_ctl,
    output logic [AW-1:0]      o_wr_addr,
    output logic [DATA_W-1:0]  o_wr_data,
    output logic [AW-1:0]      o_rd_addr,
    input  logic [DATA_W-1:0]  i_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_SCAN    = 4'b0010,
        S_RESOLVE = 4'b0100,
        S_MOVE    = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_op, n_op;
    logic [DATA_W-1:0] r_key, n_key;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_pend_idx, n_pend_idx;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic              r_valid, n_valid;
    logic              r_ok, n_ok;
    logic [1:0]        r_status, n_status;
    logic [CW-1:0]     last_idx;
    logic              hit;
    logic [CW+COUNT_W-1:0] count_ext;

    assign last_idx = r_count - CW'(1);
    assign hit      = r_pend && (i_rd_data == r_key);

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_key      = r_key;
        n_idx      = r_idx;
        n_count    = r_count;
        n_pend_idx = r_pend_idx;
        n_pend     = r_pend;
        n_found    = r_found;
        n_valid    = 1'b0;
        n_ok       = r_ok;
        n_status   = r_status;
        o_mem_ctl  = '0;
        o_wr_addr  = r_count[AW-1:0];
        o_wr_data  = r_key;
        o_rd_addr  = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_op;
                    n_key   = i_value;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_state = S_RESOLVE;
                end else if (r_idx < r_count) begin
                    // issue next read; its compare happens next cycle
                    o_mem_ctl.rd_en = 1'b1;
                    n_pend_idx      = r_idx[AW-1:0];
                    n_pend          = 1'b1;
                    n_idx           = r_idx + CW'(1);
                end else begin
                    n_found = 1'b0;
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                case (r_op)
                    OP_ADD: begin
                        if (r_found) begin
                            n_ok     = 1'b1;
                            n_status = ST_PRESENT;
                        end else if (r_count >= CW'(CAPACITY)) begin
                            n_ok     = 1'b0;
                            n_status = ST_FULL;
                        end else begin
                            o_mem_ctl.wr_en = 1'b1;
                            n_count         = r_count + CW'(1);
                            n_ok            = 1'b1;
                            n_status        = ST_DONE;
                        end
                    end
                    OP_REMOVE: begin
                        if (r_found) begin
                            // fetch last entry to refill the hole
                            o_mem_ctl.rd_en = 1'b1;
                            o_rd_addr       = last_idx[AW-1:0];
                            n_count         = last_idx;
                            n_valid         = 1'b0;
                            n_state         = S_MOVE;
                        end else begin
                            n_ok     = 1'b0;
                            n_status = ST_ABSENT;
                        end
                    end
                    default: begin
                        n_ok     = r_found;
                        n_status = r_found ? ST_PRESENT : ST_ABSENT;
                    end
                endcase
            end
            S_MOVE: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_pend_idx;
                o_wr_data       = i_rd_data;
                n_valid         = 1'b1;
                n_ok            = 1'b1;
                n_status        = ST_DONE;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_key      <= n_key;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_ok       <= n_ok;
        r_status   <= n_status;
    end

    assign count_ext    = {{COUNT_W{1'b0}}, r_count};
    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_status     = r_status;
    assign o_item_count = count_ext[COUNT_W-1:0];

endmodule

// ===== src/integer_set_table_unit.sv =====
// Top level of the integer set table: sequencer plus element store.
// Depends on ist_pkg, ist_ctrl and ist_store.
//
// A set of up to CAPACITY signed 32-bit values, kept packed and unordered
// with a fill count. A transaction is accepted when start is high and busy
// is low; i_op selects add (0), remove (1) or membership test (2; code 3
// acts as a test). Exactly one result follows per transaction: o_valid is
// high for a single cycle with o_ok, o_status (0 done, 1 already present,
// 2 not present, 3 store full) and o_item_count (count after the operation,
// low 7 bits). The receiver cannot stall the result; it must take it in
// that cycle. The scan reads one entry per cycle from the store memory
// and compares it through one shared 32-bit comparator, stopping early on
// a hit. A decide step follows; a successful remove adds a move step that
// copies the last entry into the freed slot. The strobe appears in the
// cycle busy falls. No clearing pass is needed after reset: entries at or
// above the fill count are never read.
module integer_set_table_unit
    import ist_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic [1:0]         i_op,
    input  logic signed [31:0] i_value,
    output logic               busy,
    output logic               o_valid,
    output logic               o_ok,
    output logic [1:0]         o_status,
    output logic [6:0]         o_item_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data;

    // Sequencer: scan, decide, optional move of last entry.
    ist_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (i_op),
        .i_value      (i_value),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_status     (o_status),
        .o_item_count (o_item_count),
        .o_mem_ctl    (mem_ctl),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    // Element storage, contents undefined until written.
    ist_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_mem_ctl (mem_ctl),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== dv/integer_set_table_unit_tb.sv =====
// Self-checking testbench for integer_set_table_unit: directed corner cases, then
// randomized add/remove/test traffic under three sender idling profiles.
// Depends on ist_pkg and the integer_set_table_unit RTL only.
`timescale 1ns / 1ps

module integer_set_table_unit_tb;
    import ist_pkg::*;

    localparam int CAPACITY = 64;

    // The package names only add and remove; the test codes live here.
    localparam logic [1:0] OP_TEST  = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, must behave as a test

    localparam int STALL_LIMIT  = 4000;       // cycles with no transaction at all
    localparam int MAX_REPORTS  = 10;
    localparam int POOL_SIZE    = 24;
    localparam int MIX_ITEMS    = 110;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic       ok;
        logic [1:0] status;
        logic [6:0] count;
    } t_set_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic [1:0]         i_op;
    logic signed [31:0] i_value;
    logic               busy;
    logic               o_valid;
    logic               o_ok;
    logic [1:0]         o_status;
    logic [6:0]         o_item_count;

    // Shadow copy of the set: packed members plus their count.
    logic [31:0] members [CAPACITY];
    int          member_cnt;

    t_set_reply  expected_replies[$];
    logic [31:0] key_pool [POOL_SIZE];
    int          gap_pct;
    int          err_count;

    integer_set_table_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (i_op),
        .i_value      (i_value),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_ok         (o_ok),
        .o_status     (o_status),
        .o_item_count (o_item_count)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Set predictor. Linear search over filled slots only; a remove pulls
    // the last member into the hole. Bit 1 of the op set means a test, so
    // the spare code falls into the test branch.
    // ------------------------------------------------------------------
    function automatic t_set_reply apply_set_op(input logic [1:0] op, input logic [31:0] key);
        t_set_reply r;
        int         pos;
        pos = -1;
        for (int k = 0; k < member_cnt; k++) begin
            if (pos < 0 && members[k] == key)
                pos = k;
        end
        r.ok     = 1'b0;
        r.status = ST_DONE;
        if (op == OP_ADD) begin
            if (pos >= 0) begin
                r.ok     = 1'b1;
                r.status = ST_PRESENT;
            end else if (member_cnt >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                members[member_cnt] = key;
                member_cnt++;
                r.ok = 1'b1;
            end
        end else if (op == OP_REMOVE) begin
            if (pos >= 0) begin
                member_cnt--;
                members[pos] = members[member_cnt];
                r.ok = 1'b1;
            end else begin
                r.status = ST_ABSENT;
            end
        end else begin
            r.ok     = (pos >= 0);
            r.status = (pos >= 0) ? ST_PRESENT : ST_ABSENT;
        end
        r.count = 7'(member_cnt);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Send one command transaction. Must be entered at a rising edge.
    // Each cycle the sender holds start low with probability gap_pct, so
    // idle cycles land on every phase of the scan. The prediction is taken
    // at the accepting edge; start is left as is for the next call.
    // ------------------------------------------------------------------
    task automatic send_op(input logic [1:0] op, input logic [31:0] key);
        logic taken;
        i_op    <= op;
        i_value <= key;
        taken   = 1'b0;
        while (!taken) begin
            if ($urandom_range(0, 99) < gap_pct)
                start <= 1'b0;
            else
                start <= 1'b1;
            @(posedge i_clk);
            taken = start && !busy;
        end
        expected_replies.push_back(apply_set_op(op, key));
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed corners: empty store, extreme values, duplicate add, both
    // test codes, removal from the first and last slot.
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_op(OP_TEST,   32'h0000_0000);   // test on empty store
        send_op(OP_REMOVE, 32'h0000_0000);   // remove on empty store
        send_op(OP_ADD,    32'h8000_0000);
        send_op(OP_ADD,    32'h7FFF_FFFF);
        send_op(OP_ADD,    32'hFFFF_FFFF);
        send_op(OP_ADD,    32'h0000_0000);
        send_op(OP_ADD,    32'h8000_0000);   // already present
        send_op(OP_TEST,   32'h7FFF_FFFF);
        send_op(OP_TEST,   32'h0000_0001);
        send_op(OP_SPARE,  32'hFFFF_FFFF);
        send_op(OP_SPARE,  32'h7FFF_FFFE);
        send_op(OP_REMOVE, 32'h1234_5678);   // absent
        send_op(OP_REMOVE, 32'h8000_0000);   // first slot, last moves in
        send_op(OP_TEST,   32'h0000_0000);
        send_op(OP_REMOVE, 32'h0000_0000);
        send_op(OP_TEST,   32'h8000_0000);
        send_op(OP_REMOVE, 32'hFFFF_FFFF);
        send_op(OP_ADD,    32'h5555_5555);
        send_op(OP_ADD,    32'hAAAA_AAAA);
        send_op(OP_REMOVE, 32'hAAAA_AAAA);   // last slot
        send_op(OP_REMOVE, 32'h7FFF_FFFF);
        send_op(OP_REMOVE, 32'h5555_5555);   // back to empty
        send_op(OP_ADD,    32'h0000_0000);
        wait_drained();
    endtask

    // Random mix over a small key pool so hits, misses and duplicates are common.
    task automatic test_random_mix(input int n_items);
        int          sel;
        logic [1:0]  op;
        logic [31:0] key;
        for (int k = 0; k < n_items; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                op = OP_ADD;
            else if (sel < 75)
                op = OP_REMOVE;
            else if (sel < 93)
                op = OP_TEST;
            else
                op = OP_SPARE;
            if ($urandom_range(0, 9) == 0)
                key = $urandom;
            else
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_op(op, key);
        end
    endtask

    // Fill to capacity, poke the full store, then empty it in random order.
    task automatic test_fill_and_drain();
        int sel;
        while (member_cnt < CAPACITY) begin
            sel = $urandom_range(0, 99);
            if (member_cnt > 0 && sel < 10)
                send_op(OP_ADD, members[$urandom_range(0, member_cnt - 1)]);
            else if (sel < 15)
                send_op(OP_TEST, $urandom);
            else
                send_op(OP_ADD, $urandom);
        end
        repeat (4) send_op(OP_ADD, $urandom);            // store full
        send_op(OP_ADD, members[$urandom_range(0, CAPACITY - 1)]);  // present wins over full
        send_op(OP_SPARE, members[CAPACITY - 1]);
        while (member_cnt > 0) begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
                send_op(OP_REMOVE, members[$urandom_range(0, member_cnt - 1)]);
            else if (sel < 90)
                send_op(OP_REMOVE, $urandom);
            else
                send_op(OP_TEST, members[$urandom_range(0, member_cnt - 1)]);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_set_reply want;
        if (i_rst_n && o_valid) begin
            if (expected_replies.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected result ok=%0b status=%0d count=%0d",
                             $realtime, o_ok, o_status, o_item_count);
            end else begin
                want = expected_replies.pop_front();
                if (o_ok !== want.ok || o_status !== want.status
                        || o_item_count !== want.count) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display({"%0t: mismatch exp ok=%0b status=%0d count=%0d,",
                                  " got ok=%0b status=%0d count=%0d"},
                                 $realtime, want.ok, want.status, want.count,
                                 o_ok, o_status, o_item_count);
                end
            end
        end
    end

    // Watchdog: any accepted command or result clears the stall counter.
    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy && i_rst_n) || o_valid)
                stall = 0;
            else
                stall++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_op       = OP_ADD;
        i_value    = '0;
        member_cnt = 0;
        err_count  = 0;
        gap_pct    = 12;
        for (int k = 0; k < POOL_SIZE; k++)
            key_pool[k] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();

        // Sender idling: light, then heavy, then none.
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 12 : (phase == 1) ? 64 : 0;
            test_random_mix(MIX_ITEMS);
            test_fill_and_drain();
            wait_drained();
        end

        // Let any stray strobe show up before the verdict.
        repeat (CAPACITY + 8) @(posedge i_clk);
        if (expected_replies.size() != 0)
            err_count++;
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
